>>> rtl/odf_pkg.sv
`default_nettype none

package odf_pkg;

  // Widths of the words on the channels.
  localparam int DATA_W     = 32;
  localparam int DIST_W     = 31;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 16;

  // Process and measurement variances that set the reset gain p/(p+r).
  localparam int P_VAR      = 100;
  localparam int R_VAR      = 10000;
  localparam int GAIN_RESET_INT =
    ((1 << GAIN_FRAC) * P_VAR + (P_VAR + R_VAR) / 2) / (P_VAR + R_VAR);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_RESET_INT[GAIN_W-1:0];

  // Square root unit: radicand width, root width, iteration count.
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int SQRT_ITERS = ROOT_W;
  localparam int ITER_W     = $clog2(SQRT_ITERS);

  // Largest travelled distance, the Q16.16 maximum.
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Shared multiplier operand width and product width.
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 64;

endpackage

`default_nettype wire

>>> rtl/odf_sample_if.sv
`default_nettype none

interface odf_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic        [odf_pkg::DIST_W-1:0]    measured_distance;
  logic signed [odf_pkg::DATA_W-1:0]    pos_x;
  logic signed [odf_pkg::DATA_W-1:0]    pos_y;

  modport source (output valid, output measured_distance, output pos_x, output pos_y,
                  input ready);
  modport sink   (input valid, input measured_distance, input pos_x, input pos_y,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/odf_result_if.sv
`default_nettype none

interface odf_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [odf_pkg::DATA_W-1:0]    estimated_distance;

  modport source (output valid, output estimated_distance, input ready);
  modport sink   (input valid, input estimated_distance, output ready);
endinterface

`default_nettype wire

>>> rtl/odf_cfg_if.sv
`default_nettype none

interface odf_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic        [odf_pkg::GAIN_W-1:0]    blend_gain;

  modport source (output valid, output blend_gain, input ready);
  modport sink   (input valid, input blend_gain, output ready);
endinterface

`default_nettype wire

>>> rtl/odf_isqrt.sv
`default_nettype none

// Digit-by-digit integer square root, one result bit per cycle.
module odf_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [odf_pkg::SQ_W-1:0]      value,
  output logic                               done,
  output logic      [odf_pkg::ROOT_W-1:0]    root
);

  logic [odf_pkg::SQ_W-1:0]   rem;
  logic [odf_pkg::SQ_W-1:0]   acc;
  logic [odf_pkg::SQ_W-1:0]   bitv;
  logic [odf_pkg::ITER_W-1:0] cnt;
  logic                       busy;
  logic [odf_pkg::SQ_W-1:0]   trial;

  assign trial = acc + bitv;
  assign root  = acc[odf_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= value;
        acc  <= '0;
        bitv <= {2'b01, {(odf_pkg::SQ_W-2){1'b0}}};
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == odf_pkg::ITER_W'(odf_pkg::SQRT_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/odometry_aided_distance_filter.sv
`default_nettype none

// Channel   Role   Word                                           Handshake
// sample    sink   measured_distance, pos_x, pos_y (Q16.16)       valid/ready
// result    source estimated_distance (signed Q16.16)             valid/ready
// cfg       sink   blend_gain (unsigned Q0.16)                    valid/ready
//
// Between acceptance and the loading of its result word, an ordinary item spends
// most of its time in the 32 iterations of the square root unit. A move of half the
// Q16.16 range or more on either axis skips the root and caps the distance.
// A new sample word is taken in the cycle after the result is loaded, even while
// that result waits on a stalled result channel. Reset (synchronous, active high)
// clears the estimate and position and restores the reset gain; the next sample word seeds it.
module odometry_aided_distance_filter (
  input  wire logic     clk,
  input  wire logic     rst,
  odf_sample_if.sink    sample,
  odf_result_if.source  result,
  odf_cfg_if.sink       cfg
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_ABS,
    S_SQX,
    S_SQY,
    S_SUM,
    S_ROOT,
    S_PRED,
    S_ERR,
    S_MULG,
    S_RND,
    S_CORR,
    S_OUT
  } state_t;

  state_t state;

  // Filter state.
  logic signed [odf_pkg::DATA_W-1:0] estimate;
  logic signed [odf_pkg::DATA_W-1:0] last_x;
  logic signed [odf_pkg::DATA_W-1:0] last_y;
  logic                              first_pending;
  logic        [odf_pkg::GAIN_W-1:0] blend_gain;

  // Captured sample word.
  logic        [odf_pkg::DIST_W-1:0] z_r;
  logic signed [odf_pkg::DATA_W-1:0] x_r;
  logic signed [odf_pkg::DATA_W-1:0] y_r;

  // Working registers.
  logic signed [odf_pkg::DATA_W:0]   dx;
  logic signed [odf_pkg::DATA_W:0]   dy;
  logic        [odf_pkg::DATA_W:0]   ax;
  logic        [odf_pkg::DATA_W:0]   ay;
  logic        [odf_pkg::SQ_W-1:0]   sq_acc;
  logic        [odf_pkg::DIST_W-1:0] travel;
  logic signed [odf_pkg::MUL_W-1:0]  err;
  logic signed [odf_pkg::MUL_W-1:0]  corr;
  logic signed [odf_pkg::PROD_W-1:0] prod;

  // Output register.
  logic                              out_valid;
  logic signed [odf_pkg::DATA_W-1:0] out_data;

  // Shared multiplier.
  logic signed [odf_pkg::MUL_W-1:0]   mul_a;
  logic signed [odf_pkg::MUL_W-1:0]   mul_b;
  logic signed [2*odf_pkg::MUL_W-1:0] mul_full;

  // Square root unit.
  logic                              sqrt_start;
  logic        [odf_pkg::SQ_W-1:0]   sqrt_value;
  logic                              sqrt_done;
  logic        [odf_pkg::ROOT_W-1:0] sqrt_root;

  logic                              take_sample;
  logic                              load_out;
  logic signed [odf_pkg::PROD_W-1:0] rnd;
  logic signed [odf_pkg::DATA_W+2:0] pred_sum;
  logic signed [odf_pkg::DATA_W+2:0] corr_sum;

  // Clamp a sum back into the signed Q16.16 range.
  function automatic logic signed [odf_pkg::DATA_W-1:0] sat_data(
    input logic signed [odf_pkg::DATA_W+2:0] v
  );
    logic signed [odf_pkg::DATA_W-1:0] r;
    if (v[odf_pkg::DATA_W+2:odf_pkg::DATA_W-1] == {4{v[odf_pkg::DATA_W+2]}}) begin
      r = v[odf_pkg::DATA_W-1:0];
    end else if (v[odf_pkg::DATA_W+2]) begin
      r = {1'b1, {(odf_pkg::DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(odf_pkg::DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.estimated_distance = out_data;

  assign take_sample = sample.valid && sample.ready;
  assign load_out    = (state == S_OUT) && (!out_valid || result.ready);

  // The squares use the magnitudes; the correction uses gain times error.
  always_comb begin
    case (state)
      S_SQX: begin
        mul_a = $signed({3'b000, ax[odf_pkg::DATA_W-2:0]});
        mul_b = $signed({3'b000, ax[odf_pkg::DATA_W-2:0]});
      end
      S_SQY: begin
        mul_a = $signed({3'b000, ay[odf_pkg::DATA_W-2:0]});
        mul_b = $signed({3'b000, ay[odf_pkg::DATA_W-2:0]});
      end
      default: begin
        mul_a = $signed({{(odf_pkg::MUL_W-odf_pkg::GAIN_W){1'b0}}, blend_gain});
        mul_b = err;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  assign sqrt_start = (state == S_SUM);
  assign sqrt_value = sq_acc + prod;

  // Round to nearest with ties upward, dropping the gain's fraction bits.
  assign rnd = prod + $signed(odf_pkg::PROD_W'(1) << (odf_pkg::GAIN_FRAC - 1));

  assign pred_sum = $signed({{3{estimate[odf_pkg::DATA_W-1]}}, estimate})
                  - $signed({4'b0000, travel});
  assign corr_sum = $signed({{3{estimate[odf_pkg::DATA_W-1]}}, estimate})
                  + $signed({corr[odf_pkg::MUL_W-1], corr});

  odf_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sqrt_value),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      estimate      <= '0;
      last_x        <= '0;
      last_y        <= '0;
      first_pending <= 1'b1;
      blend_gain    <= odf_pkg::GAIN_RESET;
      out_valid     <= 1'b0;
    end else begin
      prod <= mul_full[odf_pkg::PROD_W-1:0];

      if (cfg.valid && cfg.ready) begin
        blend_gain <= cfg.blend_gain;
      end

      // A word loaded in the same cycle keeps the register full.
      if (result.valid && result.ready && !load_out) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (take_sample) begin
            z_r <= sample.measured_distance;
            x_r <= sample.pos_x;
            y_r <= sample.pos_y;
            // The first word seeds the estimate and the saved position, so
            // it travels nowhere.
            if (first_pending) begin
              first_pending <= 1'b0;
              estimate      <= $signed({1'b0, sample.measured_distance});
              last_x        <= sample.pos_x;
              last_y        <= sample.pos_y;
            end
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          dx    <= $signed({x_r[odf_pkg::DATA_W-1], x_r})
                 - $signed({last_x[odf_pkg::DATA_W-1], last_x});
          dy    <= $signed({y_r[odf_pkg::DATA_W-1], y_r})
                 - $signed({last_y[odf_pkg::DATA_W-1], last_y});
          state <= S_ABS;
        end
        S_ABS: begin
          ax    <= dx[odf_pkg::DATA_W] ? $unsigned(-dx) : $unsigned(dx);
          ay    <= dy[odf_pkg::DATA_W] ? $unsigned(-dy) : $unsigned(dy);
          state <= S_SQX;
        end
        S_SQX: begin
          // A step of half the range or more saturates the distance outright.
          if (ax[odf_pkg::DATA_W:odf_pkg::DATA_W-1] != 2'b00 ||
              ay[odf_pkg::DATA_W:odf_pkg::DATA_W-1] != 2'b00) begin
            travel <= odf_pkg::DIST_MAX;
            state  <= S_PRED;
          end else begin
            state <= S_SQY;
          end
        end
        S_SQY: begin
          sq_acc <= prod;
          state  <= S_SUM;
        end
        S_SUM: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sqrt_done) begin
            travel <= sqrt_root[odf_pkg::ROOT_W-1] ? odf_pkg::DIST_MAX
                                                   : sqrt_root[odf_pkg::DIST_W-1:0];
            state  <= S_PRED;
          end
        end
        S_PRED: begin
          estimate <= sat_data(pred_sum);
          state    <= S_ERR;
        end
        S_ERR: begin
          err   <= $signed({3'b000, z_r})
                 - $signed({{2{estimate[odf_pkg::DATA_W-1]}}, estimate});
          state <= S_MULG;
        end
        S_MULG: begin
          state <= S_RND;
        end
        S_RND: begin
          corr  <= rnd[odf_pkg::GAIN_FRAC+odf_pkg::MUL_W-1:odf_pkg::GAIN_FRAC];
          state <= S_CORR;
        end
        S_CORR: begin
          estimate <= sat_data(corr_sum);
          last_x   <= x_r;
          last_y   <= y_r;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            out_valid <= 1'b1;
            out_data  <= estimate;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The root unit reports only while the sequencer waits for it.
  a_root_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == S_ROOT)
    else $error("square root finished outside its wait state");

  // Any accepted word leaves the filter seeded.
  a_seeded_after_take: assert property (@(posedge clk) disable iff (rst)
    take_sample |=> state == S_DIFF && !first_pending)
    else $error("sample word accepted without seeding the filter");

  // A loaded result carries the estimate as it stood at loading.
  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && out_data == $past(estimate))
    else $error("result word does not hold the estimate");
`endif

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none

// Testbench for odometry_aided_distance_filter.
//
// A sender task pushes sample words (sonar reading plus planar position) into
// the block, and each accepted word is run through a behavioral copy of the
// filter kept in this module. That copy yields the estimate that the block
// must return, and the estimate is queued. A checker pops the queue at every
// accepted result word and compares it. The result channel is stalled by a
// receiver process with its own random pattern, and once it holds off for a
// long stretch so that the block backs up onto the sample channel.
module tb_top;
  import odf_pkg::*;

  // Sender and receiver pacing.
  localparam int SETTLE_CYCLES   = 60;       // covers one item's passage through the block
  localparam int LONG_HOLD       = 600;      // long result stall in cycles
  localparam int WATCHDOG_CYCLES = 750_000;
  localparam int PHASE_ITEMS     = 250;

  // Handy Q16.16 values.
  localparam logic signed [DATA_W-1:0] POS_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic [DIST_W-1:0]        RANGE_MAX = {DIST_W{1'b1}};

  // Saturation bounds of the estimate and the cap on a travelled distance.
  localparam longint DATA_HI  = (64'sd1 <<< (DATA_W - 1)) - 1;
  localparam longint DATA_LO  = -DATA_HI - 1;
  localparam longint DIST_CAP = DIST_MAX;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLOCK} rx_mode_t;

  logic clk;
  logic rst;

  odf_sample_if sample_ch ();
  odf_result_if result_ch ();
  odf_cfg_if    cfg_ch ();

  odometry_aided_distance_filter dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Filter state as the block should hold it, updated once per accepted word.
  longint             filt_est    = 0;
  longint             filt_lx     = 0;
  longint             filt_ly     = 0;
  bit                 filt_seeded = 1'b0;
  logic [GAIN_W-1:0]  filt_gain   = GAIN_RESET;

  // Estimates still owed by the block, oldest first.
  logic signed [DATA_W-1:0] pending_estimates[$];

  int  mismatch_count = 0;
  int  burst_left     = 0;
  bit  gapless        = 1'b0;
  bit  hold_off_req   = 1'b0;

  // Last position sent; the random walk continues from here.
  longint walk_x = 0;
  longint walk_y = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioral filter
  // ---------------------------------------------------------------------------

  function automatic longint clamp_data(longint v);
    if (v > DATA_HI) return DATA_HI;
    if (v < DATA_LO) return DATA_LO;
    return v;
  endfunction

  // Floor of the square root, built one root bit at a time from the top. The
  // radicand stays below 2^63, so a trial root below 2^32 squares without
  // overflowing 64 bits.
  function automatic longint floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return longint'(root);
  endfunction

  // Euclidean distance from the saved position on the raw Q16.16 values. A
  // step of half the range or more on either axis goes straight to the cap.
  function automatic longint travel_dist(longint x, longint y);
    longint          dx;
    longint          dy;
    longint unsigned ax;
    longint unsigned ay;
    longint          root;
    dx = x - filt_lx;
    dy = y - filt_ly;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) return DIST_CAP;
    root = floor_root(ax * ax + ay * ay);
    return (root > DIST_CAP) ? DIST_CAP : root;
  endfunction

  // One filter update: seed on the very first word, dead-reckon by the
  // travelled distance, then pull toward the reading by the gain, rounding
  // half up at the gain's fraction bits.
  function automatic logic signed [DATA_W-1:0] predict_estimate(
      logic [DIST_W-1:0] z_in, logic signed [DATA_W-1:0] x_in,
      logic signed [DATA_W-1:0] y_in);
    longint z;
    longint x;
    longint y;
    longint prod;
    longint corr;
    z = longint'(z_in);
    x = longint'(x_in);
    y = longint'(y_in);
    if (!filt_seeded) begin
      filt_seeded = 1'b1;
      filt_lx     = x;
      filt_ly     = y;
      filt_est    = z;
    end
    filt_est = clamp_data(filt_est - travel_dist(x, y));
    prod     = longint'(filt_gain) * (z - filt_est);
    corr     = (prod + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    filt_est = clamp_data(filt_est + corr);
    filt_lx  = x;
    filt_ly  = y;
    return filt_est[DATA_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Sample channel
  // ---------------------------------------------------------------------------

  // Sends one sample word. Words go out in bursts of random length; a burst
  // starts after a random gap, which is sometimes zero, so that some stretches
  // run without any idling. The estimate is predicted when the word is taken.
  task automatic send_sample(input logic [DIST_W-1:0] z,
                             input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y);
    int gap;
    if (burst_left == 0 && !gapless) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      repeat (gap) begin
        @(negedge clk);
        sample_ch.valid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    sample_ch.valid             <= 1'b1;
    sample_ch.measured_distance <= z;
    sample_ch.pos_x             <= x;
    sample_ch.pos_y             <= y;
    do @(posedge clk); while (!sample_ch.ready);
    pending_estimates.push_back(predict_estimate(z, x, y));
    walk_x = x;
    walk_y = y;
  endtask

  function automatic longint corner_pos();
    case ($urandom_range(0, 5))
      0:       return POS_MIN;
      1:       return POS_MAX;
      2:       return 0;
      3:       return -1;
      4:       return Q_ONE;
      default: return -Q_ONE;
    endcase
  endfunction

  // Random walk word. Mostly a step of random scale from the last position
  // with a reading near the current estimate, as a robot closing on a target
  // would produce; the rest are jumps, corner positions, standstills and
  // readings drawn from the whole range.
  task automatic send_walk_item();
    longint            nx;
    longint            ny;
    longint            span;
    longint            guess;
    logic [DIST_W-1:0] z;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      span = 64'sd1 <<< $urandom_range(0, 24);
      nx = clamp_data(walk_x + longint'($urandom_range(0, int'(2 * span))) - span);
      ny = clamp_data(walk_y + longint'($urandom_range(0, int'(2 * span))) - span);
    end else if (pick < 80) begin
      nx = longint'($signed($urandom()));
      ny = longint'($signed($urandom()));
    end else if (pick < 90) begin
      nx = corner_pos();
      ny = corner_pos();
    end else begin
      nx = walk_x;
      ny = walk_y;
    end

    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      span  = 64'sd1 <<< $urandom_range(0, 20);
      guess = filt_est + longint'($urandom_range(0, int'(2 * span))) - span;
      if (guess < 0) guess = 0;
      if (guess > DIST_CAP) guess = DIST_CAP;
      z = guess[DIST_W-1:0];
    end else if (pick < 90) begin
      z = DIST_W'($urandom());
    end else begin
      z = ($urandom_range(0, 1) == 1) ? RANGE_MAX : '0;
    end
    send_sample(z, nx[DATA_W-1:0], ny[DATA_W-1:0]);
  endtask

  // Drops valid and waits until every owed estimate has come back, then lets
  // the block's latency pass so that it is surely idle.
  task automatic drain_estimates();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The gain is only rewritten while the block is idle.
  task automatic load_blend_gain(input logic [GAIN_W-1:0] g);
    drain_estimates();
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.blend_gain <= g;
    do @(posedge clk); while (!cfg_ch.ready);
    filt_gain = g;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------

  // The receiver switches between runs of free flow, light and heavy random
  // stalls and solid blocks. A hold-off request from a test overrides it with
  // the long stall set by LONG_HOLD.
  initial begin : result_receiver
    rx_mode_t mode;
    int       run_left;
    int       hold_left;
    mode      = RX_FREE;
    run_left  = 0;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          run_left = (mode == RX_BLOCK) ? $urandom_range(1, 40) : $urandom_range(20, 200);
        end
        run_left--;
        case (mode)
          RX_FREE:  result_ch.ready <= 1'b1;
          RX_LIGHT: result_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: result_ch.ready <= ($urandom_range(0, 3) == 0);
          default:  result_ch.ready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : estimate_checker
    logic signed [DATA_W-1:0] want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_estimates.size() == 0) begin
        $error("estimated_distance: expected no word, actual %0d",
               result_ch.estimated_distance);
        mismatch_count++;
      end else begin
        want = pending_estimates.pop_front();
        if (result_ch.estimated_distance !== want) begin
          $error("estimated_distance: expected %0d, actual %0d",
                 want, result_ch.estimated_distance);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Directed words at the reset gain. The first one seeds the estimate; the
  // rest hit the field extremes, moves just under half the range on each axis
  // and at half the range on x, a diagonal whose root overflows the Q16.16
  // maximum, an exact 3-4-5 move, and estimates pushed into low saturation.
  task automatic test_extremes();
    send_sample(RANGE_MAX, 0, 0);
    send_sample('0, 0, 0);
    send_sample(RANGE_MAX, Q_ONE, 0);
    send_sample(31'h0001_8000, POS_MAX, 0);
    send_sample('0, POS_MIN, 0);
    send_sample('0, POS_MIN, POS_MAX);
    send_sample(RANGE_MAX, POS_MIN, POS_MIN);
    send_sample(RANGE_MAX, -1, -1);
    send_sample('0, 0, 0);
    send_sample('0, POS_MAX, 0);
    send_sample('0, 0, 0);
    send_sample(31'h0000_0001, POS_MIN, 0);
    send_sample(RANGE_MAX, POS_MAX, POS_MAX);
    send_sample(31'h5555_5555, POS_MAX, POS_MAX);
    send_sample(31'h2AAA_AAAA, POS_MAX - 3 * Q_ONE, POS_MAX - 4 * Q_ONE);
    send_sample(31'h4000_0000, POS_MAX - 3 * Q_ONE, POS_MAX - 4 * Q_ONE);
    send_sample(31'h3FFF_FFFF, 0, POS_MIN);
  endtask

  // Short runs at the gain extremes. With a zero gain the estimate only
  // dead-reckons; at one half the correction often lands exactly on a
  // rounding tie, in both directions, since the readings are random odd and
  // even values around a standing position.
  task automatic test_gain_settings();
    load_blend_gain('0);
    repeat (6) send_sample(DIST_W'($urandom()), DATA_W'(walk_x + 5000 * Q_ONE),
                           DATA_W'(walk_y));
    load_blend_gain('1);
    repeat (6) send_walk_item();
    load_blend_gain(16'h8000);
    repeat (8) send_sample(DIST_W'($urandom()), DATA_W'(walk_x), DATA_W'(walk_y));
    load_blend_gain(16'h0001);
    repeat (4) send_walk_item();
  endtask

  // The receiver holds off for a long time while words keep coming without
  // gaps, so the block fills up and has to stall the sample channel.
  task automatic test_backpressure();
    gapless      = 1'b1;
    hold_off_req = 1'b1;
    repeat (16) send_walk_item();
    gapless    = 1'b0;
    burst_left = 0;
  endtask

  // Random walk under several gains, the reset value restored among them.
  task automatic test_random_traffic();
    logic [GAIN_W-1:0] gains[6];
    gains = '{GAIN_RESET, GAIN_W'($urandom_range(0, 65535)), '1, '0,
              GAIN_W'($urandom_range(0, 65535)), 16'h0001};
    foreach (gains[i]) begin
      load_blend_gain(gains[i]);
      repeat (PHASE_ITEMS) send_walk_item();
    end
  endtask

  initial begin
    rst                         = 1'b1;
    sample_ch.valid             = 1'b0;
    sample_ch.measured_distance = '0;
    sample_ch.pos_x             = '0;
    sample_ch.pos_y             = '0;
    cfg_ch.valid                = 1'b0;
    cfg_ch.blend_gain           = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_gain_settings();
    test_backpressure();
    test_random_traffic();

    drain_estimates();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    repeat (WATCHDOG_CYCLES) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
